// ===== rtl/sktab_pkg.sv =====
`default_nettype none

package sktab_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
        logic [31:0]        payload;
        logic [5:0]         position;
    } in_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] where;
        logic [6:0] count;
    } out_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        payload;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/sktab_chan_if.sv =====
`default_nettype none

interface sktab_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sorted_key_table_core.sv =====
// insert walks down from the top entry, moving each larger key up by one, then writes
// the new entry; search walks up from entry 0 until a key matches or the last is read;
// remove moves each later entry down by one; a refused or undefined operation skips the
// walk; one operation at a time, single read and write ports walking one entry a cycle
// reset clears the entry count and the handshake state; the entry memory is not cleared
`default_nettype none

module sorted_key_table_core #(
    parameter int DEPTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sktab_chan_if.sink   in_ch,
    sktab_chan_if.source out_ch
);

    import sktab_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 7) ? CW : 7;
    localparam int EW = $bits(entry_t);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INS   = 3'd1;
    localparam logic [2:0] ST_SRCH  = 3'd2;
    localparam logic [2:0] ST_REM   = 3'd3;
    localparam logic [2:0] ST_WRNEW = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_data_reg, out_data_next;
    in_t           cmd_reg, cmd_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic          res_ok_reg, res_ok_next;
    logic [5:0]    res_where_reg, res_where_next;

    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [AW-1:0] raddr;
    entry_t        rd_entry;
    logic [EW-1:0] rdata;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          at_last;

    sktab_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (EW'(wdata)),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_entry = entry_t'(rdata);
    assign pos_x    = XW'(in_ch.data.position);
    assign cnt_x    = XW'(count_reg);
    assign at_last  = (CW'(idx_reg) == count_reg - CW'(1));

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        res_ok_next    = res_ok_reg;
        res_where_next = res_where_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        raddr          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cmd_next       = in_ch.data;
                    res_ok_next    = 1'b0;
                    res_where_next = '0;
                    state_next     = ST_HOLD;
                    case (in_ch.data.op)
                        OP_INSERT:
                        begin
                            if (count_reg < CW'(DEPTH))
                            begin
                                if (count_reg == '0)
                                begin
                                    slot_next  = '0;
                                    state_next = ST_WRNEW;
                                end
                                else
                                begin
                                    // walk down from the top entry
                                    raddr      = AW'(count_reg - CW'(1));
                                    idx_next   = AW'(count_reg - CW'(1));
                                    state_next = ST_INS;
                                end
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                raddr      = '0;
                                idx_next   = '0;
                                state_next = ST_SRCH;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_x < cnt_x)
                            begin
                                if (pos_x + XW'(1) < cnt_x)
                                begin
                                    raddr      = AW'(pos_x + XW'(1));
                                    idx_next   = AW'(pos_x + XW'(1));
                                    state_next = ST_REM;
                                end
                                else
                                begin
                                    count_next  = count_reg - CW'(1);
                                    res_ok_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_HOLD;
                        end
                    endcase
                end
            end
            ST_INS:
            begin
                if (rd_entry.key > cmd_reg.key)
                begin
                    we    = 1'b1;
                    waddr = idx_reg + AW'(1);
                    wdata = rd_entry;
                    if (idx_reg == '0)
                    begin
                        slot_next  = '0;
                        state_next = ST_WRNEW;
                    end
                    else
                    begin
                        raddr    = idx_reg - AW'(1);
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    // new entry goes after any equal keys
                    slot_next  = idx_reg + AW'(1);
                    state_next = ST_WRNEW;
                end
            end
            ST_WRNEW:
            begin
                we             = 1'b1;
                waddr          = slot_reg;
                wdata.key      = cmd_reg.key;
                wdata.payload  = cmd_reg.payload;
                count_next     = count_reg + CW'(1);
                res_ok_next    = 1'b1;
                res_where_next = 6'(slot_reg);
                state_next     = ST_HOLD;
            end
            ST_SRCH:
            begin
                if (rd_entry.key == cmd_reg.key)
                begin
                    res_ok_next    = 1'b1;
                    res_where_next = 6'(idx_reg);
                    state_next     = ST_HOLD;
                end
                else if (at_last)
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    raddr    = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_REM:
            begin
                // move each later entry down by one
                we    = 1'b1;
                waddr = idx_reg - AW'(1);
                wdata = rd_entry;
                if (at_last)
                begin
                    count_next  = count_reg - CW'(1);
                    res_ok_next = 1'b1;
                    state_next  = ST_HOLD;
                end
                else
                begin
                    raddr    = idx_reg + AW'(1);
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next      = 1'b1;
                    out_data_next.ok    = res_ok_reg;
                    out_data_next.where = res_where_reg;
                    out_data_next.count = 7'(count_reg);
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        slot_reg      <= slot_next;
        res_ok_reg    <= res_ok_next;
        res_where_reg <= res_where_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sktab_ram.sv =====
`default_nettype none

module sktab_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
